// ----- sv/crt_pkg.sv -----
// ----------------------------------------------------------------------------
// crt_pkg
// Shared command codes, status codes and result type of the client registry.
// ----------------------------------------------------------------------------
package crt_pkg;

   localparam int ADDR_W  = 32;
   localparam int CMD_W   = 16;
   localparam int COUNT_W = 3;

   localparam logic [CMD_W-1:0] CMD_JOIN  = 16'hDCAC;
   localparam logic [CMD_W-1:0] CMD_LEAVE = 16'hACDC;
   localparam logic [CMD_W-1:0] CMD_FLUSH = 16'hAAAA;

   typedef enum logic [2:0] {
      ST_ADDED    = 3'd0,
      ST_PRESENT  = 3'd1,
      ST_FULL     = 3'd2,
      ST_REMOVED  = 3'd3,
      ST_NOTFOUND = 3'd4,
      ST_CLEARED  = 3'd5,
      ST_IGNORED  = 3'd6
   } status_type;

   // packed so that status lands in the lowest bits
   typedef struct packed {
      logic               service_stop;
      logic               service_start;
      logic               service_on;
      logic [COUNT_W-1:0] client_count;
      status_type         status;
   } result_type;

endpackage

// ----- sv/crt_core.sv -----
// ----------------------------------------------------------------------------
// crt_core
// Address table, entry count and service flag; evaluates one command a cycle while fire is high.
// ----------------------------------------------------------------------------
module crt_core #(
   parameter int TABLE_DEPTH = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fire,
   input  logic [crt_pkg::CMD_W-1:0]      command,
   input  logic [crt_pkg::ADDR_W-1:0]     client_address,
   output crt_pkg::result_type            result
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic [crt_pkg::ADDR_W-1:0] table_ff [TABLE_DEPTH];
   logic [crt_pkg::ADDR_W-1:0] table_in [TABLE_DEPTH];
   logic [crt_pkg::ADDR_W-1:0] shifted  [TABLE_DEPTH];
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   logic                       active_ff;
   logic                       active_in;
   logic [TABLE_DEPTH-1:0]     shift_mask;
   logic                       hit;
   logic                       full;
   logic                       start;
   logic                       stop;
   crt_pkg::status_type        status;

   always_comb begin
      logic seen;
      seen = 1'b0;
      // first occupied slot that matches, and every slot above it
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (!seen && (CNT_W'(i) < count_ff) && (table_ff[i] == client_address)) begin
            seen = 1'b1;
         end
         shift_mask[i] = seen;
      end
      hit = seen;

      for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
         shifted[i] = table_ff[i + 1];
      end
      shifted[TABLE_DEPTH-1] = '0;

      full      = (count_ff == CNT_W'(TABLE_DEPTH));
      table_in  = table_ff;
      count_in  = count_ff;
      active_in = active_ff;
      start     = 1'b0;
      stop      = 1'b0;
      status    = crt_pkg::ST_IGNORED;

      case (command)
         crt_pkg::CMD_JOIN: begin
            if (full) begin
               status = crt_pkg::ST_FULL;
            end else if (hit) begin
               status = crt_pkg::ST_PRESENT;
            end else begin
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (CNT_W'(i) == count_ff) begin
                     table_in[i] = client_address;
                  end
               end
               count_in = count_ff + CNT_W'(1);
               status   = crt_pkg::ST_ADDED;
            end
            if ((count_in == CNT_W'(1)) && !active_ff) begin
               active_in = 1'b1;
               start     = 1'b1;
            end
         end
         crt_pkg::CMD_LEAVE: begin
            if (hit) begin
               // slots above the count are always zero, so the top fills with zero
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (shift_mask[i]) begin
                     table_in[i] = shifted[i];
                  end
               end
               count_in = count_ff - CNT_W'(1);
               status   = crt_pkg::ST_REMOVED;
            end else begin
               status = crt_pkg::ST_NOTFOUND;
            end
            if ((count_in == '0) && active_ff) begin
               active_in = 1'b0;
               stop      = 1'b1;
            end
         end
         crt_pkg::CMD_FLUSH: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               table_in[i] = '0;
            end
            count_in = '0;
            if (active_ff) begin
               active_in = 1'b0;
               stop      = 1'b1;
            end
            status = crt_pkg::ST_CLEARED;
         end
         default: begin
            status = crt_pkg::ST_IGNORED;
         end
      endcase

      result.status        = status;
      result.client_count  = crt_pkg::COUNT_W'(count_in);
      result.service_on    = active_in;
      result.service_start = start;
      result.service_stop  = stop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            table_ff[i] <= '0;
         end
         count_ff  <= '0;
         active_ff <= 1'b0;
      end else if (fire) begin
         table_ff  <= table_in;
         count_ff  <= count_in;
         active_ff <= active_in;
      end
   end

`ifndef SYNTHESIS
   // the service runs exactly while the table holds an address
   a_active_matches_count: assert property (@(posedge clock) disable iff (reset)
      active_ff == (count_ff != '0))
      else $error("service flag out of step with entry count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count exceeds table depth");

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      fire && (command == crt_pkg::CMD_FLUSH) |=> (count_ff == '0) && !active_ff)
      else $error("disconnect-all left entries behind");

   a_start_only_on_add: assert property (@(posedge clock) disable iff (reset)
      fire && start |-> (status == crt_pkg::ST_ADDED) && !stop)
      else $error("service start without an added client");
`endif

endmodule

// ----- sv/client_registry_table.sv -----
// ----------------------------------------------------------------------------
// client_registry_table
// Registry of up to TABLE_DEPTH client addresses that switches a service.
// ----------------------------------------------------------------------------
// Each request transfer carries a command word and a client address and gives
// exactly one response transfer with the status, the client count after the
// command and the service flags. Requests pass through an input register, are
// evaluated combinationally against the table by a parallel compare and shift
// across all slots, and land in an output register: one transfer per cycle
// sustained while responses are taken. The input register captures the request
// at its transfer and the output register captures the result when evaluation
// fires, once the output register is free. A waiting response stalls evaluation
// only; the input register still takes a new request while it is empty, or
// while the output register is free or being drained.
module client_registry_table #(
   parameter int TABLE_DEPTH = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // command [15:0], client_address [47:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // status [2:0], client_count [5:3], service_on [6],
                                    // service_start [7], service_stop [8], zero [15:9]
);

   logic                           in_valid_ff;
   logic                           in_valid_in;
   logic [crt_pkg::CMD_W-1:0]      command_ff;
   logic [crt_pkg::ADDR_W-1:0]     address_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   crt_pkg::result_type            rsp_ff;
   crt_pkg::result_type            result;
   logic                           out_free;
   logic                           fire;
   logic                           req_xfer;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         command_ff <= req_tdata[15:0];
         address_ff <= req_tdata[47:16];
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   crt_core #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .command        (command_ff),
      .client_address (address_ff),
      .result         (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_ff};

endmodule

// ----- tb/tb_client_registry_table.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_client_registry_table
// Self-checking bench for the client address registry.
// ----------------------------------------------------------------------------
// Streams connect, disconnect, disconnect-all and ignored command words into
// the registry. A behavioral copy of the table, the count and the service flag
// predicts every response, and each response transfer is checked field by
// field against the oldest prediction. A directed sequence covers the table
// edges first. Three random phases follow: mostly response-side stalls, then
// mostly request-side stalls, then full throughput. Addresses come mostly from a
// small pool so that connects and disconnects keep hitting each other.
// ----------------------------------------------------------------------------
module tb_client_registry_table;

   localparam int TABLE_DEPTH  = 5;
   localparam int PIPE_LATENCY = 2;
   localparam int STALL_LIMIT  = 4000;
   localparam int POOL_SIZE    = 8;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // command [15:0], client_address [47:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // status [2:0], client_count [5:3], service_on [6],
                                   // service_start [7], service_stop [8], zero [15:9]

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count   = 0;
   int stall_cycles  = 0;

   // behavioral copy of the registry
   logic [crt_pkg::ADDR_W-1:0] client_slots [TABLE_DEPTH];
   int                         client_total = 0;
   logic                       service_live = 1'b0;
   crt_pkg::result_type        registry_outcomes [$];
   logic [crt_pkg::ADDR_W-1:0] address_pool [POOL_SIZE];

   client_registry_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #4 clock = ~clock;

   initial begin
      foreach (client_slots[i]) client_slots[i] = '0;
   end

   function automatic int find_client(logic [crt_pkg::ADDR_W-1:0] addr);
      for (int i = 0; i < client_total && i < TABLE_DEPTH; i++) begin
         if (client_slots[i] == addr) return i;
      end
      return -1;
   endfunction

   function automatic crt_pkg::result_type apply_command(logic [crt_pkg::CMD_W-1:0] cmd,
                                                         logic [crt_pkg::ADDR_W-1:0] addr);
      crt_pkg::result_type r;
      int                  slot;
      r = '0;
      r.status = crt_pkg::ST_IGNORED;
      if (cmd == crt_pkg::CMD_JOIN) begin
         if (client_total >= TABLE_DEPTH) begin
            r.status = crt_pkg::ST_FULL;
         end else if (find_client(addr) >= 0) begin
            r.status = crt_pkg::ST_PRESENT;
         end else begin
            client_slots[client_total] = addr;
            client_total++;
            r.status = crt_pkg::ST_ADDED;
         end
         if (client_total == 1 && !service_live) begin
            service_live    = 1'b1;
            r.service_start = 1'b1;
         end
      end else if (cmd == crt_pkg::CMD_LEAVE) begin
         slot = find_client(addr);
         if (slot >= 0) begin
            for (int i = slot; i + 1 < client_total; i++) client_slots[i] = client_slots[i+1];
            client_total--;
            client_slots[client_total] = '0;
            r.status = crt_pkg::ST_REMOVED;
         end else begin
            r.status = crt_pkg::ST_NOTFOUND;
         end
         if (client_total == 0 && service_live) begin
            service_live   = 1'b0;
            r.service_stop = 1'b1;
         end
      end else if (cmd == crt_pkg::CMD_FLUSH) begin
         foreach (client_slots[i]) client_slots[i] = '0;
         client_total = 0;
         if (service_live) begin
            service_live   = 1'b0;
            r.service_stop = 1'b1;
         end
         r.status = crt_pkg::ST_CLEARED;
      end
      r.client_count = client_total[crt_pkg::COUNT_W-1:0];
      r.service_on   = service_live;
      return r;
   endfunction

   // valid stays high from the previous transfer unless an idle cycle is drawn
   task automatic send_command(input logic [crt_pkg::CMD_W-1:0] cmd,
                               input logic [crt_pkg::ADDR_W-1:0] addr);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {addr, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      registry_outcomes.push_back(apply_command(cmd, addr));
   endtask

   task automatic drain_registry();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (registry_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_command(16'h0000, 32'h0000_0000);
      send_command(crt_pkg::CMD_LEAVE, 32'h0000_0000);   // nothing to remove, no stop pulse
      send_command(crt_pkg::CMD_FLUSH, 32'h0000_0000);   // clear while already off
      send_command(crt_pkg::CMD_JOIN, 32'h0000_0000);    // zero address, service start
      send_command(crt_pkg::CMD_JOIN, 32'h0000_0000);
      send_command(16'hFFFF, 32'hFFFF_FFFF);
      send_command(crt_pkg::CMD_LEAVE, 32'h0000_0000);
      send_command(crt_pkg::CMD_JOIN, 32'h0000_0001);
      send_command(crt_pkg::CMD_JOIN, 32'hFFFF_FFFF);
      send_command(crt_pkg::CMD_JOIN, 32'h8000_0000);
      send_command(crt_pkg::CMD_JOIN, 32'h7FFF_FFFF);
      send_command(crt_pkg::CMD_JOIN, 32'h1234_5678);
      send_command(crt_pkg::CMD_JOIN, 32'h0BAD_F00D);    // table full
      send_command(crt_pkg::CMD_JOIN, 32'h0000_0001);    // full wins over already present
      send_command(crt_pkg::CMD_LEAVE, 32'h8000_0000);   // removal from a full table
      send_command(crt_pkg::CMD_LEAVE, 32'h0000_0000);   // cleared slot must not match
      send_command(crt_pkg::CMD_JOIN, 32'h0000_0000);
      send_command(crt_pkg::CMD_LEAVE, 32'h0000_0000);   // last slot
      send_command(crt_pkg::CMD_LEAVE, 32'h0000_0001);   // first slot
      send_command(crt_pkg::CMD_JOIN ^ 16'h0001, 32'h5555_5555);
      send_command(crt_pkg::CMD_LEAVE ^ 16'h8000, 32'hAAAA_AAAA);
      send_command(crt_pkg::CMD_FLUSH, 32'hFFFF_FFFF);   // clear while active
      send_command(crt_pkg::CMD_JOIN, 32'hA5A5_A5A5);
      send_command(crt_pkg::CMD_LEAVE, 32'hA5A5_A5A5);
      send_command(crt_pkg::CMD_FLUSH, 32'h0000_0000);
      drain_registry();
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int item_total);
      int                         sent;
      int                         pick;
      logic [crt_pkg::CMD_W-1:0]  cmd;
      logic [crt_pkg::ADDR_W-1:0] addr;
      send_idle_pct   = send_pct;
      recv_idle_pct   = recv_pct;
      address_pool[0] = 32'h0000_0000;
      address_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) address_pool[i] = $urandom;
      sent = 0;
      while (sent < item_total) begin
         pick = $urandom_range(99);
         if (pick < 45) cmd = crt_pkg::CMD_JOIN;
         else if (pick < 80) cmd = crt_pkg::CMD_LEAVE;
         else if (pick < 84) cmd = crt_pkg::CMD_FLUSH;
         else if (pick < 92) cmd = 16'($urandom_range(65535));
         else begin
            // one bit off a real code
            case ($urandom_range(2))
               0: cmd = crt_pkg::CMD_JOIN;
               1: cmd = crt_pkg::CMD_LEAVE;
               default: cmd = crt_pkg::CMD_FLUSH;
            endcase
            cmd = cmd ^ (16'h0001 << $urandom_range(15));
         end
         if ($urandom_range(99) < 85) addr = address_pool[$urandom_range(POOL_SIZE-1)];
         else addr = $urandom;
         send_command(cmd, addr);
         sent++;
      end
      drain_registry();
   endtask

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      crt_pkg::result_type got;
      crt_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = crt_pkg::result_type'(rsp_tdata[8:0]);
         if (registry_outcomes.size() == 0) begin
            $display("%0t unexpected response: expected none actual %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = registry_outcomes.pop_front();
            check_field("status", want.status, got.status);
            check_field("client_count", want.client_count, got.client_count);
            check_field("service_on", want.service_on, got.service_on);
            check_field("service_start", want.service_start, got.service_start);
            check_field("service_stop", want.service_stop, got.service_stop);
            check_field("padding", 0, rsp_tdata[15:9]);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("client_registry_table verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_traffic(36, 47, 625);
      test_random_traffic(47, 36, 625);
      test_random_traffic(0, 0, 625);
      repeat (PIPE_LATENCY * 4) @(posedge clock);
      if (registry_outcomes.size() != 0) begin
         $display("%0t responses missing: expected 0 actual %0d", $time,
                  registry_outcomes.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("client_registry_table verification clean");
      end else begin
         $display("client_registry_table verification failed");
      end
      $finish;
   end

endmodule
